// ===== design/assert_macros.svh =====
// Assertion helpers used by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/pts_pkg.sv =====
package pts_pkg;

   // Field widths of the request and response beats and the configuration registers.
   localparam int OpW     = 2;
   localparam int SlotW   = 3;
   localparam int TimeW   = 32;
   localparam int TickW   = 16;
   localparam int LimitW  = 4;
   localparam int CsrIdxW = 2;
   localparam int CsrW    = 16;

   // Request operations.
   localparam logic [OpW-1:0] OP_TICK     = 2'd0;
   localparam logic [OpW-1:0] OP_REGISTER = 2'd1;
   localparam logic [OpW-1:0] OP_ENABLE   = 2'd2;

   // Configuration register indexes.
   localparam logic [CsrIdxW-1:0] CSR_BASE_TICK   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_CATCH_UP_ON = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CATCH_LIMIT = 2'd2;

   // Defaults and limits.
   localparam logic [TickW-1:0]  DefaultTick  = 16'd1;
   localparam logic [LimitW-1:0] DefaultLimit = 4'd5;
   localparam int                MaxResults   = 60;
   localparam int                CountW       = 6;

   // Sequencer program counter and step addresses.
   localparam int PcW = 3;
   localparam logic [PcW-1:0] PC_WAIT  = 3'd0;
   localparam logic [PcW-1:0] PC_SCAN  = 3'd1;
   localparam logic [PcW-1:0] PC_SEL   = 3'd2;
   localparam logic [PcW-1:0] PC_RUN   = 3'd3;
   localparam logic [PcW-1:0] PC_FLUSH = 3'd4;

   // Jump condition selects.
   localparam int CondW = 3;
   localparam logic [CondW-1:0] COND_TICK     = 3'd0;
   localparam logic [CondW-1:0] COND_SCAN_END = 3'd1;
   localparam logic [CondW-1:0] COND_ACTIVE   = 3'd2;
   localparam logic [CondW-1:0] COND_MORE     = 3'd3;
   localparam logic [CondW-1:0] COND_ALWAYS   = 3'd4;

   // One microcode word: datapath strobes plus a two-way jump.
   typedef struct packed {
      logic             req_rdy;   // take request beats in this step
      logic             emit;      // try to issue a run event for the current slot
      logic             flush;     // release the held event as the final one
      logic             clr_runs;  // restart the per-slot run counter
      logic             adv_f;     // step to the next slot when the jump is not taken
      logic [CondW-1:0] cond;
      logic [PcW-1:0]   tgt_t;
      logic [PcW-1:0]   tgt_f;
   } ctl_word_type;

   // Control store.
   function automatic ctl_word_type ucode(input logic [PcW-1:0] pc);
      ctl_word_type w;
      w = '{req_rdy: 1'b1, emit: 1'b0, flush: 1'b0, clr_runs: 1'b0, adv_f: 1'b0,
            cond: COND_TICK, tgt_t: PC_SCAN, tgt_f: PC_WAIT};
      case (pc)
         PC_WAIT: begin
            w = '{req_rdy: 1'b1, emit: 1'b0, flush: 1'b0, clr_runs: 1'b0, adv_f: 1'b0,
                  cond: COND_TICK, tgt_t: PC_SCAN, tgt_f: PC_WAIT};
         end
         PC_SCAN: begin
            w = '{req_rdy: 1'b0, emit: 1'b0, flush: 1'b0, clr_runs: 1'b0, adv_f: 1'b0,
                  cond: COND_SCAN_END, tgt_t: PC_FLUSH, tgt_f: PC_SEL};
         end
         PC_SEL: begin
            w = '{req_rdy: 1'b0, emit: 1'b0, flush: 1'b0, clr_runs: 1'b1, adv_f: 1'b1,
                  cond: COND_ACTIVE, tgt_t: PC_RUN, tgt_f: PC_SCAN};
         end
         PC_RUN: begin
            w = '{req_rdy: 1'b0, emit: 1'b1, flush: 1'b0, clr_runs: 1'b0, adv_f: 1'b1,
                  cond: COND_MORE, tgt_t: PC_RUN, tgt_f: PC_SCAN};
         end
         PC_FLUSH: begin
            w = '{req_rdy: 1'b0, emit: 1'b0, flush: 1'b1, clr_runs: 1'b0, adv_f: 1'b0,
                  cond: COND_ALWAYS, tgt_t: PC_WAIT, tgt_f: PC_WAIT};
         end
         default: begin
            w = '{req_rdy: 1'b0, emit: 1'b0, flush: 1'b0, clr_runs: 1'b0, adv_f: 1'b0,
                  cond: COND_ALWAYS, tgt_t: PC_WAIT, tgt_f: PC_WAIT};
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/pts_if.sv =====
// Request channel: one beat per command.
interface pts_req_if;
   import pts_pkg::*;
   logic                valid;
   logic                ready;
   logic [OpW-1:0]      op;
   logic [SlotW-1:0]    slot;
   logic [TimeW-1:0]    period;
   logic                enable;
   modport source (output valid, op, slot, period, enable, input ready);
   modport sink   (input valid, op, slot, period, enable, output ready);
endinterface

// Response channel: one beat per run event.
interface pts_rsp_if;
   import pts_pkg::*;
   logic                valid;
   logic                ready;
   logic [SlotW-1:0]    run_slot;
   logic [TimeW-1:0]    scheduled_time;
   logic [TimeW-1:0]    run_period;
   logic [TimeW-1:0]    clock_now;
   logic                last;
   modport source (output valid, run_slot, scheduled_time, run_period, clock_now, last,
                   input ready);
   modport sink   (input valid, run_slot, scheduled_time, run_period, clock_now, last,
                   output ready);
endinterface

// ===== design/periodic_task_scheduler.sv =====
// Periodic task scheduler.
// Request beats (req_bus) carry an op: tick, register a slot, or set a slot's enable.
// Register and enable beats update the slot table and give no response.
// A tick advances the millisecond clock by base_tick (1 if zero), then walks the slots
// in order; every due, enabled, registered slot issues run events on rsp_bus, one per
// elapsed period (several per tick with catch-up on, up to the catch-up limit).
// The final event of a tick carries last = 1; a tick with no due slot gives none.
// The microcoded sequencer walks the slots one step at a time, one event per cycle
// while the output is free. Request ready is high only while the sequencer sits in
// its wait step, so the next beat is taken once the previous tick has moved its last
// event into the output register. One event is held back until the next is known,
// so it can be marked last; an output register holds the beat for the receiver.
// When rsp_bus stalls and an event must move out, the sequencer freezes in place
// and loses nothing.
// Reset (synchronous, active high) clears the clock, all slot registrations and
// enables, and loads the configuration defaults (tick 1, catch-up off, limit 5).
// Configuration is written through csr_we / csr_index / csr_wdata; the user must
// write it only while idle, which the block does not enforce.
`include "assert_macros.svh"

module periodic_task_scheduler
   import pts_pkg::*;
#(
   parameter int SLOT_COUNT   = 5,
   parameter int MAX_CATCH_UP = 12
) (
   input  logic                clock,
   input  logic                reset,
   pts_req_if.sink             req_bus,
   pts_rsp_if.source           rsp_bus,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrW-1:0]     csr_wdata
);

   localparam int SlotCntW = $clog2(SLOT_COUNT + 1);
   localparam int SlotIdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Configuration registers.
   logic [TickW-1:0]  base_tick_ff;
   logic              catch_on_ff;
   logic [LimitW-1:0] catch_limit_ff;

   // Sequencer and datapath state.
   logic [PcW-1:0]      pc_ff, pc_in;
   logic [SlotCntW-1:0] sidx_ff, sidx_in;
   logic [LimitW-1:0]   runs_ff, runs_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic [TimeW-1:0]    clock_ff, clock_in;

   // Slot table.
   logic [TimeW-1:0] period_ff [SLOT_COUNT];
   logic [TimeW-1:0] period_in [SLOT_COUNT];
   logic [TimeW-1:0] due_ff    [SLOT_COUNT];
   logic [TimeW-1:0] due_in    [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] en_ff, en_in;
   logic [SLOT_COUNT-1:0] regd_ff, regd_in;

   // Held-back event, waiting to learn whether it is the last one.
   logic             pend_valid_ff, pend_valid_in;
   logic [SlotW-1:0] pend_slot_ff, pend_slot_in;
   logic [TimeW-1:0] pend_sched_ff, pend_sched_in;
   logic [TimeW-1:0] pend_period_ff, pend_period_in;
   logic [TimeW-1:0] pend_now_ff, pend_now_in;

   // Response output register.
   logic             out_valid_ff, out_valid_in;
   logic [SlotW-1:0] out_slot_ff, out_slot_in;
   logic [TimeW-1:0] out_sched_ff, out_sched_in;
   logic [TimeW-1:0] out_period_ff, out_period_in;
   logic [TimeW-1:0] out_now_ff, out_now_in;
   logic             out_last_ff, out_last_in;

   ctl_word_type        uc;
   logic [SlotIdxW-1:0] idx;
   logic [SlotIdxW-1:0] wr_idx;
   logic                wr_in_range;
   logic                req_fire;
   logic                tick_fire;
   logic [TickW-1:0]    tick_eff;
   logic [LimitW-1:0]   lim_raw;
   logic [LimitW-1:0]   lim;
   logic                due_hit;
   logic                more;
   logic                out_free;
   logic                stall;
   logic                cond_hit;
   logic                do_emit;
   logic                do_flush;

   // Fetch the control word of the current step.
   assign uc = ucode(pc_ff);

   assign idx         = sidx_ff[SlotIdxW-1:0];
   assign wr_idx      = req_bus.slot[SlotIdxW-1:0];
   assign wr_in_range = ({29'd0, req_bus.slot} < 32'(SLOT_COUNT));

   assign req_bus.ready = uc.req_rdy;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign tick_fire     = req_fire && (req_bus.op == OP_TICK);

   // Effective tick and catch-up limit.
   assign tick_eff = (base_tick_ff == '0) ? DefaultTick : base_tick_ff;
   assign lim_raw  = (catch_limit_ff == '0) ? DefaultLimit : catch_limit_ff;
   assign lim      = (lim_raw > LimitW'(MAX_CATCH_UP)) ? LimitW'(MAX_CATCH_UP) : lim_raw;

   // Due test for the current slot, and whether another run may follow.
   assign due_hit = (clock_ff >= due_ff[idx]) && (count_ff < CountW'(MaxResults));
   assign more    = catch_on_ff && (({1'b0, runs_ff} + 5'd1) < {1'b0, lim});

   // The sequencer freezes when an event must move out but the output is busy.
   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign stall    = ((uc.emit && due_hit) || uc.flush) && pend_valid_ff && !out_free;
   assign do_emit  = uc.emit && due_hit && !stall;
   assign do_flush = uc.flush && pend_valid_ff && !stall;

   // Jump condition select.
   always_comb begin
      case (uc.cond)
         COND_TICK:     cond_hit = tick_fire;
         COND_SCAN_END: cond_hit = (sidx_ff == SlotCntW'(SLOT_COUNT));
         COND_ACTIVE:   cond_hit = en_ff[idx] && regd_ff[idx];
         COND_MORE:     cond_hit = due_hit && more;
         COND_ALWAYS:   cond_hit = 1'b1;
         default:       cond_hit = 1'b0;
      endcase
   end

   // Next-state logic for sequencer, slot table, held event and output register.
   always_comb begin
      pc_in          = pc_ff;
      sidx_in        = sidx_ff;
      runs_in        = runs_ff;
      count_in       = count_ff;
      clock_in       = clock_ff;
      period_in      = period_ff;
      due_in         = due_ff;
      en_in          = en_ff;
      regd_in        = regd_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_sched_in  = pend_sched_ff;
      pend_period_in = pend_period_ff;
      pend_now_in    = pend_now_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      out_slot_in    = out_slot_ff;
      out_sched_in   = out_sched_ff;
      out_period_in  = out_period_ff;
      out_now_in     = out_now_ff;
      out_last_in    = out_last_ff;

      if (!stall) begin
         pc_in = cond_hit ? uc.tgt_t : uc.tgt_f;
         if (uc.adv_f && !cond_hit) begin
            sidx_in = sidx_ff + SlotCntW'(1);
         end
         if (uc.clr_runs) begin
            runs_in = '0;
         end
      end

      // Request beats: start a tick, or update the slot table.
      if (tick_fire) begin
         clock_in = clock_ff + {16'd0, tick_eff};
         sidx_in  = '0;
         count_in = '0;
      end
      if (req_fire && (req_bus.op == OP_REGISTER) && wr_in_range &&
          (req_bus.period != '0)) begin
         period_in[wr_idx] = req_bus.period;
         due_in[wr_idx]    = clock_ff + req_bus.period;
         en_in[wr_idx]     = req_bus.enable;
         regd_in[wr_idx]   = 1'b1;
      end
      if (req_fire && (req_bus.op == OP_ENABLE) && wr_in_range) begin
         en_in[wr_idx] = req_bus.enable;
      end

      // A new run event pushes the held one out as a non-final beat.
      if (do_emit) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_slot_in   = pend_slot_ff;
            out_sched_in  = pend_sched_ff;
            out_period_in = pend_period_ff;
            out_now_in    = pend_now_ff;
            out_last_in   = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_slot_in   = SlotW'(sidx_ff);
         pend_sched_in  = due_ff[idx];
         pend_period_in = period_ff[idx];
         pend_now_in    = clock_ff;
         due_in[idx]    = due_ff[idx] + period_ff[idx];
         runs_in        = runs_ff + LimitW'(1);
         count_in       = count_ff + CountW'(1);
      end

      // End of the walk: the held event is the final one.
      if (do_flush) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_slot_in   = pend_slot_ff;
         out_sched_in  = pend_sched_ff;
         out_period_in = pend_period_ff;
         out_now_in    = pend_now_ff;
         out_last_in   = 1'b1;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= PC_WAIT;
         sidx_ff       <= '0;
         runs_ff       <= '0;
         count_ff      <= '0;
         clock_ff      <= '0;
         en_ff         <= '0;
         regd_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         sidx_ff       <= sidx_in;
         runs_ff       <= runs_in;
         count_ff      <= count_in;
         clock_ff      <= clock_in;
         en_ff         <= en_in;
         regd_ff       <= regd_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      period_ff      <= period_in;
      due_ff         <= due_in;
      pend_slot_ff   <= pend_slot_in;
      pend_sched_ff  <= pend_sched_in;
      pend_period_ff <= pend_period_in;
      pend_now_ff    <= pend_now_in;
      out_slot_ff    <= out_slot_in;
      out_sched_ff   <= out_sched_in;
      out_period_ff  <= out_period_in;
      out_now_ff     <= out_now_in;
      out_last_ff    <= out_last_in;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_tick_ff   <= DefaultTick;
         catch_on_ff    <= 1'b0;
         catch_limit_ff <= DefaultLimit;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BASE_TICK:   base_tick_ff   <= csr_wdata;
            CSR_CATCH_UP_ON: catch_on_ff    <= csr_wdata[0];
            CSR_CATCH_LIMIT: catch_limit_ff <= csr_wdata[LimitW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Response beat.
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.run_slot       = out_slot_ff;
   assign rsp_bus.scheduled_time = out_sched_ff;
   assign rsp_bus.run_period     = out_period_ff;
   assign rsp_bus.clock_now      = out_now_ff;
   assign rsp_bus.last           = out_last_ff;

   // A tick always restarts the walk with an empty event count.
   `ASSERT_NEXT(a_tick_start, clock, reset, tick_fire, (pc_ff == PC_SCAN) && (count_ff == '0))
   // Back in the wait step, no event may still be held back.
   `ASSERT_IMPLIES(a_no_lost_event, clock, reset, pc_ff == PC_WAIT, !pend_valid_ff)
   // Runs of one slot stay under the catch-up limit.
   `ASSERT_IMPLIES(a_run_limit, clock, reset, pc_ff == PC_RUN, runs_ff < lim)
   // Events per tick never pass the cap.
   `ASSERT_IMPLIES(a_count_cap, clock, reset, 1'b1, count_ff <= CountW'(MaxResults))

endmodule

// ===== tb/sv/tb_periodic_task_scheduler.sv =====
`timescale 1ns / 100ps

module tb_periodic_task_scheduler;
   import pts_pkg::*;

   localparam int NumSlots     = 5;
   localparam int MaxCatchUp   = 12;
   localparam int SettleCycles = 100;
   localparam int DrainLimit   = 50000;
   localparam int PhaseItems   = 72;
   localparam logic [OpW-1:0] OpUnused = 2'd3;

   // One run event as it appears on the response channel.
   typedef struct packed {
      logic [SlotW-1:0] run_slot;
      logic [TimeW-1:0] scheduled_time;
      logic [TimeW-1:0] run_period;
      logic [TimeW-1:0] clock_now;
      logic             last;
   } run_event_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [CsrW-1:0]    csr_wdata;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();

   periodic_task_scheduler #(
      .SLOT_COUNT   (NumSlots),
      .MAX_CATCH_UP (MaxCatchUp)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Scheduler state as the testbench expects it to be.
   logic [TickW-1:0]  cfg_base_tick;
   logic              cfg_catch_up;
   logic [LimitW-1:0] cfg_limit;
   logic [TimeW-1:0]  clock_ms;
   logic [TimeW-1:0]  slot_due [NumSlots];
   logic [TimeW-1:0]  slot_period [NumSlots];
   logic              slot_enabled [NumSlots];
   logic              slot_registered [NumSlots];

   run_event_type expected_runs[$];

   bit idle_on;
   int mismatches;
   int cmds_sent;
   int ticks_sent;
   int events_checked;
   int settings_used;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the scheduler hangs.
   initial begin
      #8_000_000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [TimeW-1:0] got,
                              input logic [TimeW-1:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   // Applies one accepted command to the expected state and queues the run
   // events that a tick causes. The newest event is held back so that the
   // final one of the tick can be marked last.
   function automatic void step_schedule(input logic [OpW-1:0] op,
                                         input logic [SlotW-1:0] slot,
                                         input logic [TimeW-1:0] period,
                                         input logic en);
      run_event_type    held;
      bit               have_held;
      int               count;
      int               runs;
      int               lim;
      int               s;
      logic [TimeW-1:0] step;
      have_held = 1'b0;
      count = 0;
      case (op)
         OP_REGISTER: begin
            if (slot < NumSlots && period != '0) begin
               slot_period[slot] = period;
               slot_enabled[slot] = en;
               slot_registered[slot] = 1'b1;
               slot_due[slot] = clock_ms + period;
            end
         end
         OP_ENABLE: begin
            if (slot < NumSlots) slot_enabled[slot] = en;
         end
         OP_TICK: begin
            // A zero tick counts as the default tick.
            step = TimeW'((cfg_base_tick == '0) ? DefaultTick : cfg_base_tick);
            clock_ms = clock_ms + step;
            // A zero limit falls back to the default; large limits saturate.
            lim = int'((cfg_limit == '0) ? DefaultLimit : cfg_limit);
            if (lim > MaxCatchUp) lim = MaxCatchUp;
            for (s = 0; s < NumSlots; s++) begin
               if (slot_enabled[s] && slot_registered[s]) begin
                  runs = 0;
                  while (clock_ms >= slot_due[s] && count < MaxResults) begin
                     if (have_held) expected_runs.push_back(held);
                     held.run_slot = SlotW'(s);
                     held.scheduled_time = slot_due[s];
                     held.run_period = slot_period[s];
                     held.clock_now = clock_ms;
                     held.last = 1'b0;
                     have_held = 1'b1;
                     count++;
                     slot_due[s] = slot_due[s] + slot_period[s];
                     runs++;
                     if (!cfg_catch_up || runs >= lim) break;
                  end
               end
            end
            if (have_held) begin
               held.last = 1'b1;
               expected_runs.push_back(held);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Sends one command beat, with an optional gap ahead of it, and updates
   // the expected state once the beat is taken.
   task automatic send_cmd(input logic [OpW-1:0] op, input logic [SlotW-1:0] slot,
                           input logic [TimeW-1:0] period, input logic en);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.op     <= op;
      req_bus.slot   <= slot;
      req_bus.period <= period;
      req_bus.enable <= en;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      step_schedule(op, slot, period, en);
      cmds_sent++;
      if (op == OP_TICK) ticks_sent++;
   endtask

   // Waits until every expected run event has come back, then lets a tick
   // that gives no events finish its slot walk.
   task automatic drain_runs();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (expected_runs.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      if (expected_runs.size() != 0) begin
         report_mismatch($sformatf("%0d run events never arrived", expected_runs.size()));
         expected_runs.delete();
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   // Writes all three registers on consecutive cycles while the block is idle.
   task automatic apply_settings(input logic [TickW-1:0] tick, input logic on,
                                 input logic [LimitW-1:0] limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_BASE_TICK;
      csr_wdata <= tick;
      @(posedge clock);
      csr_index <= CSR_CATCH_UP_ON;
      csr_wdata <= CsrW'(on);
      @(posedge clock);
      csr_index <= CSR_CATCH_LIMIT;
      csr_wdata <= CsrW'(limit);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_base_tick = tick;
      cfg_catch_up = on;
      cfg_limit = limit;
      settings_used++;
   endtask

   // Mostly ticks and registrations with periods scaled to the tick, so
   // slots fall due and catch up; the rest is enables and ignored commands.
   task automatic run_random_cmds(input int count);
      int               pick;
      int               i;
      logic [TimeW-1:0] span;
      logic [TimeW-1:0] per;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         span = TimeW'((cfg_base_tick == '0) ? DefaultTick : cfg_base_tick);
         if (pick < 48) begin
            send_cmd(OP_TICK, SlotW'($urandom_range(0, 7)), $urandom,
                     1'($urandom_range(0, 1)));
         end else if (pick < 74) begin
            case ($urandom_range(0, 3))
               0: per = $urandom_range(1, 20);
               1: per = $urandom_range(1, span * 4);
               2: per = $urandom;
               default: per = 32'hFFFF_FFFF - $urandom_range(0, span * 3);
            endcase
            send_cmd(OP_REGISTER, SlotW'($urandom_range(0, NumSlots - 1)), per,
                     $urandom_range(0, 5) != 0);
         end else if (pick < 90) begin
            send_cmd(OP_ENABLE, SlotW'($urandom_range(0, 7)), $urandom,
                     $urandom_range(0, 3) != 0);
         end else if (pick < 97) begin
            if (pick % 2 == 0) begin
               send_cmd(OP_REGISTER, SlotW'($urandom_range(NumSlots, 7)), $urandom,
                        1'($urandom_range(0, 1)));
            end else begin
               send_cmd(OP_REGISTER, SlotW'($urandom_range(0, NumSlots - 1)), '0,
                        1'($urandom_range(0, 1)));
            end
         end else begin
            send_cmd(OpUnused, SlotW'($urandom_range(0, 7)), $urandom,
                     1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Ignored commands, basic registration and once-per-tick runs at reset
   // settings, including a period that wraps the due time past zero.
   task automatic test_reset_defaults();
      send_cmd(OpUnused, 3'd7, 32'hFFFF_FFFF, 1'b1);
      send_cmd(OP_ENABLE, 3'd7, 32'h0, 1'b1);
      send_cmd(OP_REGISTER, 3'd5, 32'd3, 1'b1);
      send_cmd(OP_REGISTER, 3'd0, 32'd0, 1'b1);
      send_cmd(OP_TICK, 3'd0, 32'h0, 1'b0);
      send_cmd(OP_REGISTER, 3'd0, 32'd1, 1'b1);
      send_cmd(OP_REGISTER, 3'd4, 32'd3, 1'b1);
      send_cmd(OP_REGISTER, 3'd1, 32'd2, 1'b0);
      send_cmd(OP_REGISTER, 3'd3, 32'hFFFF_FFFF, 1'b1);
      send_cmd(OP_REGISTER, 3'd2, 32'h8000_0000, 1'b1);
      repeat (4) send_cmd(OP_TICK, 3'd0, 32'h0, 1'b0);
      send_cmd(OP_ENABLE, 3'd1, 32'h0, 1'b1);
      repeat (2) send_cmd(OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1);
      send_cmd(OP_ENABLE, 3'd0, 32'h0, 1'b0);
      send_cmd(OP_TICK, 3'd0, 32'h0, 1'b0);
      send_cmd(OP_ENABLE, 3'd6, 32'h0, 1'b0);
      send_cmd(OP_REGISTER, 3'd6, 32'd5, 1'b0);
      send_cmd(OP_TICK, 3'd0, 32'h0, 1'b0);
   endtask

   // Largest tick with the highest catch-up limit.
   task automatic test_catch_up_at_max_tick();
      drain_runs();
      apply_settings(16'hFFFF, 1'b1, 4'd12);
      run_random_cmds(PhaseItems);
   endtask

   // A zero tick acts as one and a zero limit as the default limit.
   task automatic test_zero_tick_default_limit();
      drain_runs();
      apply_settings(16'h0000, 1'b1, 4'd0);
      run_random_cmds(PhaseItems);
   endtask

   // A limit above the maximum is clamped to the maximum.
   task automatic test_saturated_limit();
      drain_runs();
      apply_settings(16'd37, 1'b1, 4'd15);
      run_random_cmds(PhaseItems);
   endtask

   // Catch-up on, but at most one run per slot per tick.
   task automatic test_single_run_limit();
      drain_runs();
      apply_settings(16'd20, 1'b1, 4'd1);
      run_random_cmds(PhaseItems);
   endtask

   // Catch-up off at a random tick, with both channels running flat out.
   task automatic test_catch_up_off_no_idling();
      drain_runs();
      idle_on = 1'b0;
      apply_settings(TickW'($urandom_range(1, 200)), 1'b0, LimitW'($urandom_range(0, 15)));
      run_random_cmds(PhaseItems);
   endtask

   // Response ready: random stall bursts while idling is on.
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Compare every response beat with the oldest expected run event.
   always @(posedge clock) begin : run_checker
      run_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_runs.size() == 0) begin
            report_mismatch($sformatf("unexpected run event for slot %0d", rsp_bus.run_slot));
         end else begin
            want = expected_runs.pop_front();
            check_field("run_slot", TimeW'(rsp_bus.run_slot), TimeW'(want.run_slot));
            check_field("scheduled_time", rsp_bus.scheduled_time, want.scheduled_time);
            check_field("run_period", rsp_bus.run_period, want.run_period);
            check_field("clock_now", rsp_bus.clock_now, want.clock_now);
            check_field("last", TimeW'(rsp_bus.last), TimeW'(want.last));
            events_checked++;
         end
      end
   end

   // Reset, then the tests in turn.
   initial begin
      int i;
      idle_on = 1'b1;
      mismatches = 0;
      cmds_sent = 0;
      ticks_sent = 0;
      events_checked = 0;
      settings_used = 1;
      cfg_base_tick = DefaultTick;
      cfg_catch_up = 1'b0;
      cfg_limit = DefaultLimit;
      clock_ms = '0;
      for (i = 0; i < NumSlots; i++) begin
         slot_due[i] = '0;
         slot_period[i] = '0;
         slot_enabled[i] = 1'b0;
         slot_registered[i] = 1'b0;
      end
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_BASE_TICK;
      csr_wdata      <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.op     <= OP_TICK;
      req_bus.slot   <= '0;
      req_bus.period <= '0;
      req_bus.enable <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_catch_up_at_max_tick();
      test_zero_tick_default_limit();
      test_saturated_limit();
      test_single_run_limit();
      test_catch_up_off_no_idling();
      drain_runs();

      $display("Sent %0d commands (%0d ticks) under %0d register settings.",
               cmds_sent, ticks_sent, settings_used);
      $display("Checked %0d run events; %0d mismatches.", events_checked, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/pts_pkg.sv
design/pts_if.sv
design/periodic_task_scheduler.sv
tb/sv/tb_periodic_task_scheduler.sv
